@@ hdl/hcs_pkg.sv @@
// Shared types and constants of the cubic Hermite curve sampler.
package hcs_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 11;
    localparam int FRAC_W  = 16;

    // Parameter division: numerator j*2^16 + (n-1)/2, quotient bits per stage
    localparam int NUM_W      = 27;
    localparam int QUO_W      = 18;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    // t in Q1.16, at most 1.0
    localparam int T_W = 17;

    // Basis value widths: h1 and h2 span a little over [0,1], h3, h4 and h3+h4 stay small
    localparam int HW_W  = 18;
    localparam int HS_W  = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd250;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] m0;
        logic signed [COORD_W-1:0] m1;
    } geom_t;

    // Geometry plus the index error flag that rides along every stage
    typedef struct packed {
        geom_t geom;
        logic  err;
    } carry_t;

    typedef struct packed {
        carry_t            c;
        logic [NUM_W-1:0]  num;
    } div_req_t;

    typedef struct packed {
        carry_t          c;
        logic [T_W-1:0]  t;
    } div_rsp_t;

    typedef struct packed {
        carry_t                   c;
        logic signed [HW_W-1:0]   h1;
        logic signed [HW_W-1:0]   h2;
        logic signed [HW_W-1:0]   h34;
        logic signed [HS_W-1:0]   h3;
        logic signed [HS_W-1:0]   h4;
    } basis_t;

endpackage

@@ hdl/hcs_divider.sv @@
// Pipelined restoring divider that forms t = round(j*2^16 / (n-1)).
module hcs_divider #(
    parameter int DW = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hcs_pkg::div_req_t  in_data,
    input  logic [DW-1:0]      divisor,
    output logic               out_valid,
    input  logic               out_ready,
    output hcs_pkg::div_rsp_t  out_data
);

    localparam int RW = DW + 1;
    localparam int S  = hcs_pkg::DIV_STAGES;

    typedef struct packed {
        hcs_pkg::carry_t                c;
        logic [hcs_pkg::NUM_W-1:0]      num;
        logic [hcs_pkg::QUO_W-1:0]      quo;
        logic [RW-1:0]                  rem;
    } dstage_t;

    dstage_t        entry;
    dstage_t        stg     [S+1];
    dstage_t        st_next [S];
    dstage_t        st_reg  [S];
    logic [S-1:0]   v_reg;
    logic [S:0]     vin;
    logic [S:0]     en;
    logic [RW-1:0]  dext;

    assign dext = {1'b0, divisor};

    // Seed the remainder with the numerator bits above the quotient
    always_comb
    begin
        entry.c   = in_data.c;
        entry.num = in_data.num;
        entry.quo = '0;
        entry.rem = RW'(in_data.num >> hcs_pkg::QUO_W);
    end

    assign stg[0] = entry;
    assign vin    = {v_reg, in_valid};

    // Advance a stage when it is empty or the next one advances
    assign en[S]    = out_ready;
    assign in_ready = en[0];

    for (genvar k = 0; k < S; k++)
    begin : g_stage
        assign stg[k+1] = st_reg[k];
        assign en[k]    = !v_reg[k] || en[k+1];

        // Retire three quotient bits, most significant first
        always_comb
        begin
            dstage_t       cur;
            logic [RW-1:0] trial;
            cur = stg[k];
            for (int b = 0; b < hcs_pkg::DIV_BITS; b++)
            begin
                trial = {cur.rem[RW-2:0],
                         cur.num[hcs_pkg::QUO_W-1-k*hcs_pkg::DIV_BITS-b]};
                if (trial >= dext)
                begin
                    cur.rem = trial - dext;
                    cur.quo[hcs_pkg::QUO_W-1-k*hcs_pkg::DIV_BITS-b] = 1'b1;
                end
                else
                begin
                    cur.rem = trial;
                    cur.quo[hcs_pkg::QUO_W-1-k*hcs_pkg::DIV_BITS-b] = 1'b0;
                end
            end
            st_next[k] = cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en[k])
                v_reg[k] <= vin[k];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid  = v_reg[S-1];
    assign out_data.c = st_reg[S-1].c;
    assign out_data.t = st_reg[S-1].quo[hcs_pkg::T_W-1:0];

endmodule

@@ hdl/hcs_basis.sv @@
// Three-stage evaluator of the four Hermite basis polynomials from t.
module hcs_basis (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hcs_pkg::div_rsp_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hcs_pkg::basis_t    out_data
);

    localparam logic signed [51:0] ONE_Q48 = 52'sh1000000000000;
    localparam logic signed [51:0] RND_32  = 52'sh0000080000000;

    logic [2:0]                 v_reg;
    logic [3:0]                 en;

    logic [33:0]                sq_prod;
    logic [49:0]                cu_prod;

    logic [hcs_pkg::T_W-1:0]    s1_t_reg;
    logic [32:0]                s1_t2_reg;
    hcs_pkg::carry_t            s1_c_reg;

    logic [hcs_pkg::T_W-1:0]    s2_t_reg;
    logic [32:0]                s2_t2_reg;
    logic [48:0]                s2_t3_reg;
    hcs_pkg::carry_t            s2_c_reg;

    hcs_pkg::basis_t            s3_next;
    hcs_pkg::basis_t            s3_reg;

    // Advance a stage when it is empty or the next one advances
    assign en[3]    = out_ready;
    assign en[2]    = !v_reg[2] || en[3];
    assign en[1]    = !v_reg[1] || en[2];
    assign en[0]    = !v_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            if (en[1])
                v_reg[1] <= v_reg[0];
            if (en[2])
                v_reg[2] <= v_reg[1];
        end
    end

    // Square and cube of t, exact
    assign sq_prod = 34'(in_data.t) * 34'(in_data.t);
    assign cu_prod = 50'(s1_t2_reg) * 50'(s1_t_reg);

    // Combine powers in Q48 and round each basis value to Q16
    always_comb
    begin
        logic signed [51:0] a;
        logic signed [51:0] b;
        logic signed [51:0] c;
        logic signed [51:0] r3;
        logic signed [51:0] r4;
        a  = $signed({3'b000, s2_t3_reg});
        b  = $signed({3'b000, s2_t2_reg, 16'h0000});
        c  = $signed({3'b000, s2_t_reg, 32'h0000_0000});
        r3 = (a - (b <<< 1) + c + RND_32) >>> 32;
        r4 = (a - b + RND_32) >>> 32;
        s3_next.c   = s2_c_reg;
        s3_next.h1  = hcs_pkg::HW_W'(((a <<< 1) - (b <<< 1) - b + ONE_Q48 + RND_32) >>> 32);
        s3_next.h2  = hcs_pkg::HW_W'(((b <<< 1) + b - (a <<< 1) + RND_32) >>> 32);
        s3_next.h3  = hcs_pkg::HS_W'(r3);
        s3_next.h4  = hcs_pkg::HS_W'(r4);
        s3_next.h34 = hcs_pkg::HW_W'(r3 + r4);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_t_reg  <= in_data.t;
            s1_t2_reg <= sq_prod[32:0];
            s1_c_reg  <= in_data.c;
        end
        if (en[1])
        begin
            s2_t_reg  <= s1_t_reg;
            s2_t2_reg <= s1_t2_reg;
            s2_t3_reg <= cu_prod[48:0];
            s2_c_reg  <= s1_c_reg;
        end
        if (en[2])
            s3_reg <= s3_next;
    end

    assign out_valid = v_reg[2];
    assign out_data  = s3_reg;

endmodule

@@ hdl/hcs_combine.sv @@
// Six-stage weighted sum of endpoints and slope terms, rounding and saturation.
module hcs_combine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  hcs_pkg::basis_t                     in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hcs_pkg::COORD_W-1:0]  out_x,
    output logic signed [hcs_pkg::COORD_W-1:0]  out_y,
    output logic                                out_err
);

    localparam int NS = 6;

    logic [NS-1:0]  v_reg;
    logic [NS:0]    en;

    // Stage 1: dx and endpoint products
    logic signed [32:0]  dx_next;
    logic signed [49:0]  px0_next, px1_next, py0_next, py1_next;
    logic signed [32:0]  c1_dx_reg;
    logic signed [49:0]  c1_px0_reg, c1_px1_reg, c1_py0_reg, c1_py1_reg;
    logic signed [31:0]  c1_m0_reg, c1_m1_reg;
    logic signed [15:0]  c1_h3_reg, c1_h4_reg;
    logic signed [17:0]  c1_h34_reg;
    logic                c1_err_reg;

    // Stage 2: slope times dx, tangent term of x
    logic signed [64:0]  md0p_next, md1p_next;
    logic signed [50:0]  pdx_next;
    logic signed [64:0]  c2_md0p_reg, c2_md1p_reg;
    logic signed [50:0]  c2_pdx_reg;
    logic signed [49:0]  c2_px0_reg, c2_px1_reg, c2_py0_reg, c2_py1_reg;
    logic signed [15:0]  c2_h3_reg, c2_h4_reg;
    logic                c2_err_reg;

    // Stage 3: round slope terms, sum x and the endpoint part of y
    logic signed [48:0]  md0_next, md1_next;
    logic signed [63:0]  sx_next, syp_next;
    logic signed [48:0]  c3_md0_reg, c3_md1_reg;
    logic signed [63:0]  c3_sx_reg, c3_syp_reg;
    logic signed [15:0]  c3_h3_reg, c3_h4_reg;
    logic                c3_err_reg;

    // Stage 4: slope products of y
    logic signed [63:0]  q0_next, q1_next;
    logic signed [63:0]  c4_q0_reg, c4_q1_reg;
    logic signed [63:0]  c4_sx_reg, c4_syp_reg;
    logic                c4_err_reg;

    // Stage 5: full y sum
    logic signed [63:0]  sy_next;
    logic signed [63:0]  c5_sx_reg, c5_sy_reg;
    logic                c5_err_reg;

    // Stage 6: output word
    logic signed [31:0]  x_next, y_next;
    logic signed [31:0]  c6_x_reg, c6_y_reg;
    logic                c6_err_reg;

    // Round a Q32 sum to Q16 and clamp to the 32-bit range
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] s);
        logic signed [63:0] r;
        r = (s + 64'sd32768) >>> 16;
        if (r > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (r < 64'shFFFF_FFFF_8000_0000)
            return 32'sh8000_0000;
        else
            return 32'(r);
    endfunction

    // Advance a stage when it is empty or the next one advances
    assign en[NS]   = out_ready;
    assign in_ready = en[0];
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Datapath of each stage
    always_comb
    begin
        dx_next   = 33'(in_data.c.geom.x1) - 33'(in_data.c.geom.x0);
        px0_next  = 50'(in_data.h1) * 50'(in_data.c.geom.x0);
        px1_next  = 50'(in_data.h2) * 50'(in_data.c.geom.x1);
        py0_next  = 50'(in_data.h1) * 50'(in_data.c.geom.y0);
        py1_next  = 50'(in_data.h2) * 50'(in_data.c.geom.y1);

        md0p_next = 65'(c1_m0_reg) * 65'(c1_dx_reg);
        md1p_next = 65'(c1_m1_reg) * 65'(c1_dx_reg);
        pdx_next  = 51'(c1_h34_reg) * 51'(c1_dx_reg);

        md0_next  = 49'((c2_md0p_reg + 65'sd32768) >>> 16);
        md1_next  = 49'((c2_md1p_reg + 65'sd32768) >>> 16);
        sx_next   = 64'(c2_px0_reg) + 64'(c2_px1_reg) + 64'(c2_pdx_reg);
        syp_next  = 64'(c2_py0_reg) + 64'(c2_py1_reg);

        q0_next   = 64'(c3_h3_reg) * 64'(c3_md0_reg);
        q1_next   = 64'(c3_h4_reg) * 64'(c3_md1_reg);

        sy_next   = c4_syp_reg + c4_q0_reg + c4_q1_reg;

        // Drop the sample to zero on an index error
        if (c5_err_reg)
        begin
            x_next = '0;
            y_next = '0;
        end
        else
        begin
            x_next = round_sat(c5_sx_reg);
            y_next = round_sat(c5_sy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1_dx_reg  <= dx_next;
            c1_px0_reg <= px0_next;
            c1_px1_reg <= px1_next;
            c1_py0_reg <= py0_next;
            c1_py1_reg <= py1_next;
            c1_m0_reg  <= in_data.c.geom.m0;
            c1_m1_reg  <= in_data.c.geom.m1;
            c1_h3_reg  <= in_data.h3;
            c1_h4_reg  <= in_data.h4;
            c1_h34_reg <= in_data.h34;
            c1_err_reg <= in_data.c.err;
        end
        if (en[1])
        begin
            c2_md0p_reg <= md0p_next;
            c2_md1p_reg <= md1p_next;
            c2_pdx_reg  <= pdx_next;
            c2_px0_reg  <= c1_px0_reg;
            c2_px1_reg  <= c1_px1_reg;
            c2_py0_reg  <= c1_py0_reg;
            c2_py1_reg  <= c1_py1_reg;
            c2_h3_reg   <= c1_h3_reg;
            c2_h4_reg   <= c1_h4_reg;
            c2_err_reg  <= c1_err_reg;
        end
        if (en[2])
        begin
            c3_md0_reg <= md0_next;
            c3_md1_reg <= md1_next;
            c3_sx_reg  <= sx_next;
            c3_syp_reg <= syp_next;
            c3_h3_reg  <= c2_h3_reg;
            c3_h4_reg  <= c2_h4_reg;
            c3_err_reg <= c2_err_reg;
        end
        if (en[3])
        begin
            c4_q0_reg  <= q0_next;
            c4_q1_reg  <= q1_next;
            c4_sx_reg  <= c3_sx_reg;
            c4_syp_reg <= c3_syp_reg;
            c4_err_reg <= c3_err_reg;
        end
        if (en[4])
        begin
            c5_sx_reg  <= c4_sx_reg;
            c5_sy_reg  <= sy_next;
            c5_err_reg <= c4_err_reg;
        end
        if (en[5])
        begin
            c6_x_reg   <= x_next;
            c6_y_reg   <= y_next;
            c6_err_reg <= c5_err_reg;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_x     = c6_x_reg;
    assign out_y     = c6_y_reg;
    assign out_err   = c6_err_reg;

endmodule

@@ hdl/hermite_curve_sampler_top.sv @@
// Top level of the cubic Hermite curve sampler: config register, index check, pipeline.
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  start_x..end_slope, sample_index
//  curve     out        curve_valid / curve_stall    curve_x, curve_y, index_error
//  cfg       in         cfg_valid / cfg_ready        cfg_data (samples_per_segment)
//
//  One word per clock while curve_stall stays low; the pipeline holds one input stage,
//  six divider stages of three quotient bits each, three basis stages, six summing stages.
//  Each stage advances when it is empty or its successor advances, so bubbles close up
//  and curve_stall backs the pipeline up stage by stage until sample_stall rises.
//  Reset empties the pipeline and loads samples_per_segment with 250; cfg_ready is
//  always high.
module hermite_curve_sampler_top #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [hcs_pkg::COORD_W-1:0]  start_x,
    input  logic signed [hcs_pkg::COORD_W-1:0]  start_y,
    input  logic signed [hcs_pkg::COORD_W-1:0]  end_x,
    input  logic signed [hcs_pkg::COORD_W-1:0]  end_y,
    input  logic signed [hcs_pkg::COORD_W-1:0]  start_slope,
    input  logic signed [hcs_pkg::COORD_W-1:0]  end_slope,
    input  logic [hcs_pkg::IDX_W-1:0]           sample_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hcs_pkg::CFG_W-1:0]           cfg_data,
    output logic                                curve_valid,
    input  logic                                curve_stall,
    output logic signed [hcs_pkg::COORD_W-1:0]  curve_x,
    output logic signed [hcs_pkg::COORD_W-1:0]  curve_y,
    output logic                                index_error
);

    localparam int DW = $clog2(MAX_SAMPLES);
    localparam int NW = DW + 1;

    logic [hcs_pkg::CFG_W-1:0]  spc_reg;
    logic [NW-1:0]              n_lim;
    logic [DW-1:0]              d_val;
    logic                       idx_err;

    hcs_pkg::div_req_t          s0_next;
    hcs_pkg::div_req_t          s0_reg;
    logic                       s0_v_reg;
    logic                       s0_en;

    logic                       div_ready;
    logic                       div_valid;
    hcs_pkg::div_rsp_t          div_data;
    logic                       bas_ready;
    logic                       bas_valid;
    hcs_pkg::basis_t            bas_data;
    logic                       cmb_ready;

    // Take a config word on every handshake
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spc_reg <= hcs_pkg::CFG_RESET;
        else if (cfg_valid && cfg_ready)
            spc_reg <= cfg_data;
    end

    // Clamp the sample count, form n-1 and check the index
    always_comb
    begin
        if (32'(spc_reg) > 32'(MAX_SAMPLES))
            n_lim = NW'(MAX_SAMPLES);
        else
            n_lim = NW'(spc_reg);
        d_val   = DW'(n_lim - NW'(1));
        idx_err = (n_lim < NW'(2)) || (32'(sample_index) >= 32'(n_lim));
    end

    // Build the rounded division numerator j*2^16 + (n-1)/2
    always_comb
    begin
        s0_next.c.geom.x0 = start_x;
        s0_next.c.geom.y0 = start_y;
        s0_next.c.geom.x1 = end_x;
        s0_next.c.geom.y1 = end_y;
        s0_next.c.geom.m0 = start_slope;
        s0_next.c.geom.m1 = end_slope;
        s0_next.c.err     = idx_err;
        s0_next.num       = hcs_pkg::NUM_W'({sample_index, {hcs_pkg::FRAC_W{1'b0}}})
                          + hcs_pkg::NUM_W'(d_val >> 1);
    end

    // Input stage: hold while full and the divider cannot take it
    assign s0_en        = !s0_v_reg || div_ready;
    assign sample_stall = !s0_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (s0_en)
            s0_v_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_en)
            s0_reg <= s0_next;
    end

    hcs_divider #(
        .DW (DW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_v_reg),
        .in_ready  (div_ready),
        .in_data   (s0_reg),
        .divisor   (d_val),
        .out_valid (div_valid),
        .out_ready (bas_ready),
        .out_data  (div_data)
    );

    hcs_basis u_basis (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (bas_ready),
        .in_data   (div_data),
        .out_valid (bas_valid),
        .out_ready (cmb_ready),
        .out_data  (bas_data)
    );

    hcs_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bas_valid),
        .in_ready  (cmb_ready),
        .in_data   (bas_data),
        .out_valid (curve_valid),
        .out_ready (!curve_stall),
        .out_x     (curve_x),
        .out_y     (curve_y),
        .out_err   (index_error)
    );

endmodule

@@ verif/tb_hermite_curve_sampler_top.sv @@
// Self-checking testbench for the cubic Hermite curve sampler top level.
module tb_hermite_curve_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = hcs_pkg::COORD_W;
    localparam int IDX_W   = hcs_pkg::IDX_W;
    localparam int CFG_W   = hcs_pkg::CFG_W;
    localparam logic [CFG_W-1:0] CFG_RESET = hcs_pkg::CFG_RESET;

    localparam int MAX_SAMPLES  = 1024;
    localparam int PIPE_LATENCY = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_STRETCH = 80;

    localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] m0;
        logic signed [COORD_W-1:0] m1;
        logic [IDX_W-1:0]          idx;
    } seg_sample_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      err;
    } curve_word_t;

    logic                       clk;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic signed [COORD_W-1:0]  start_slope;
    logic signed [COORD_W-1:0]  end_slope;
    logic [IDX_W-1:0]           sample_index;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           cfg_data;
    logic                       curve_valid;
    logic                       curve_stall;
    logic signed [COORD_W-1:0]  curve_x;
    logic signed [COORD_W-1:0]  curve_y;
    logic                       index_error;

    // Shadow of samples_per_segment and the curve words still owed by the block
    logic [CFG_W-1:0] count_shadow = CFG_RESET;
    curve_word_t      curve_due[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;
    int errors        = 0;
    int quiet_cycles  = 0;
    int curves_seen   = 0;

    hermite_curve_sampler_top #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .start_slope (start_slope),
        .end_slope   (end_slope),
        .sample_index(sample_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .curve_valid (curve_valid),
        .curve_stall (curve_stall),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .index_error (index_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Round to nearest, ties toward plus infinity (arithmetic shift is a floor)
    function automatic longint round_q(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_q16(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return v[COORD_W-1:0];
    endfunction

    // Expected curve point for one sample under the given sample count
    function automatic curve_word_t hermite_point(input seg_sample_t s,
                                                  input logic [CFG_W-1:0] count);
        longint n, d, j, t, t2, t3, t2w, tw, unit;
        longint h1, h2, h3, h4;
        longint x0, y0, x1, y1, m0, m1, dx, md0, md1, sx, sy;
        curve_word_t r;
        r.x   = '0;
        r.y   = '0;
        r.err = 1'b1;
        n = count;
        if (n > MAX_SAMPLES)
            n = MAX_SAMPLES;
        j = s.idx;
        // too few samples to form t, or index past the segment
        if (n < 2 || j >= n)
            return r;

        d    = n - 1;
        t    = ((j << 16) + (d >> 1)) / d;
        t2   = t * t;
        t3   = t2 * t;
        t2w  = t2 << 16;
        tw   = t << 32;
        unit = longint'(1) << 48;
        h1 = round_q(2 * t3 - 3 * t2w + unit, 32);
        h2 = round_q(-2 * t3 + 3 * t2w, 32);
        h3 = round_q(t3 - 2 * t2w + tw, 32);
        h4 = round_q(t3 - t2w, 32);

        x0 = s.x0;
        y0 = s.y0;
        x1 = s.x1;
        y1 = s.y1;
        m0 = s.m0;
        m1 = s.m1;
        dx  = x1 - x0;
        md0 = round_q(m0 * dx, 16);
        md1 = round_q(m1 * dx, 16);
        sx  = h1 * x0 + h2 * x1 + (h3 + h4) * dx;
        sy  = h1 * y0 + h2 * y1 + h3 * md0 + h4 * md1;

        r.x   = clamp_q16(round_q(sx, 16));
        r.y   = clamp_q16(round_q(sy, 16));
        r.err = 1'b0;
        return r;
    endfunction

    function automatic seg_sample_t make_sample(
        input logic signed [COORD_W-1:0] x0, input logic signed [COORD_W-1:0] y0,
        input logic signed [COORD_W-1:0] x1, input logic signed [COORD_W-1:0] y1,
        input logic signed [COORD_W-1:0] m0, input logic signed [COORD_W-1:0] m1,
        input int idx);
        seg_sample_t s;
        s.x0  = x0;
        s.y0  = y0;
        s.x1  = x1;
        s.y1  = y1;
        s.m0  = m0;
        s.m1  = m1;
        s.idx = idx[IDX_W-1:0];
        return s;
    endfunction

    // Random value sign-extended from the given number of bits
    function automatic logic signed [COORD_W-1:0] rand_span(input int bits);
        logic signed [COORD_W-1:0] v;
        v = $urandom;
        return (v <<< (COORD_W - bits)) >>> (COORD_W - bits);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_edge();
        case ($urandom_range(5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic seg_sample_t random_sample();
        seg_sample_t s;
        int top;
        case ($urandom_range(3))
            0, 1:
            begin
                // plausible geometry: points within +-4096.0, slopes within +-8.0
                s.x0 = rand_span(29);
                s.y0 = rand_span(29);
                s.x1 = rand_span(29);
                s.y1 = rand_span(29);
                s.m0 = rand_span(20);
                s.m1 = rand_span(20);
            end
            2:
            begin
                s.x0 = $urandom;
                s.y0 = $urandom;
                s.x1 = $urandom;
                s.y1 = $urandom;
                s.m0 = $urandom;
                s.m1 = $urandom;
            end
            default:
            begin
                s.x0 = pick_edge();
                s.y0 = pick_edge();
                s.x1 = pick_edge();
                s.y1 = pick_edge();
                s.m0 = pick_edge();
                s.m1 = pick_edge();
            end
        endcase
        top = (count_shadow > MAX_SAMPLES) ? MAX_SAMPLES - 1 : int'(count_shadow) - 1;
        // mostly valid indexes, the rest anywhere in the field
        if (top >= 1 && $urandom_range(99) < 88)
            s.idx = $urandom_range(top);
        else
            s.idx = $urandom_range((1 << IDX_W) - 1);
        return s;
    endfunction

    function automatic logic [CFG_W-1:0] pick_count();
        case ($urandom_range(9))
            0: return $urandom_range(2, 5);
            1: return $urandom_range(MAX_SAMPLES + 1, (1 << CFG_W) - 1);
            2: return $urandom_range(0, 1);
            3: return MAX_SAMPLES;
            default: return $urandom_range(2, MAX_SAMPLES);
        endcase
    endfunction

    task automatic flag_error(input string what);
        if (errors < 10)
            $display("mismatch at curve word %0d: %s", curves_seen, what);
        errors++;
    endtask

    // Offer one sample word, hold it until taken, then log its expected curve word
    task automatic send_sample(input seg_sample_t s);
        // keep the sender idle while a draw falls under the requested odds
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        start_x      <= s.x0;
        start_y      <= s.y0;
        end_x        <= s.x1;
        end_y        <= s.y1;
        start_slope  <= s.m0;
        end_slope    <= s.m1;
        sample_index <= s.idx;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        curve_due.insert(curve_due.size(), hermite_point(s, count_shadow));
    endtask

    // Drop valid and wait until every owed curve word has come back
    task automatic wait_drained();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (curve_due.size() != 0);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        count_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // reset count of 250: both endpoints, midpoint, indexes past the end
        send_sample(make_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh000A_0000,
                                32'sh0005_0000, 32'sh0001_8000, -32'sh0000_8000, 0));
        send_sample(make_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh000A_0000,
                                32'sh0005_0000, 32'sh0001_8000, -32'sh0000_8000, 249));
        send_sample(make_sample(-32'sh0003_0000, 32'sh0007_4000, 32'sh0010_0000,
                                -32'sh0002_0000, 32'sh0000_4000, 32'sh0003_0000, 124));
        send_sample(make_sample(32'sh1234_5678, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 250));
        send_sample(make_sample(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1023));
        // field extremes, widest dx and largest slope products, saturation
        send_sample(make_sample(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 100));
        send_sample(make_sample(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 100));
        send_sample(make_sample(Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 62));
        send_sample(make_sample(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, 187));
        send_sample(make_sample('0, '0, '0, '0, '0, '0, 0));

        // smallest usable count: t is exactly 0 or 1
        write_count(11'd2);
        send_sample(make_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                32'sh0004_0000, Q_MAX, Q_MIN, 0));
        send_sample(make_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                32'sh0004_0000, Q_MAX, Q_MIN, 1));
        send_sample(make_sample(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                32'sh0004_0000, Q_MAX, Q_MIN, 2));
        // count too small: every index rejected
        write_count(11'd0);
        send_sample(make_sample(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0));
        write_count(11'd1);
        send_sample(make_sample(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0));
        send_sample(make_sample(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1));
        // count too large: treated as the maximum, so index 1023 is the end point
        write_count(11'd2047);
        send_sample(make_sample(32'sh0005_0000, -32'sh0005_0000, -32'sh0009_0000,
                                32'sh0009_0000, 32'sh0002_0000, 32'sh0001_0000, 1023));
        send_sample(make_sample(32'sh0005_0000, -32'sh0005_0000, -32'sh0009_0000,
                                32'sh0009_0000, 32'sh0002_0000, 32'sh0001_0000, 0));
        write_count(11'd1024);
        send_sample(make_sample(Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1023));
        write_count(11'd1025);
        send_sample(make_sample(32'sh0100_0000, 32'sh0, -32'sh0100_0000, 32'sh0,
                                -32'sh0004_0000, 32'sh0004_0000, 512));
        // three samples: t of one half exactly, then the end point
        write_count(11'd3);
        send_sample(make_sample(-32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000,
                                32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 1));
        send_sample(make_sample(-32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000,
                                32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 2));
    endtask

    // Hold the receiver off long enough that the pipeline fills and stalls the input
    task automatic test_backpressure();
        write_count(11'd250);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = HOLD_STRETCH;
        repeat (40) send_sample(random_sample());
    endtask

    task automatic test_random_flow(input int send_pct, input int recv_pct, input int words);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        for (int k = 0; k < words; k++)
        begin
            if (k % 70 == 0)
                write_count(pick_count());
            send_sample(random_sample());
        end
    endtask

    // Drive curve_stall: a requested hold first, random stalls otherwise
    initial
    begin
        curve_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                curve_stall <= 1'b1;
                hold_cycles--;
            end
            else
                curve_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check each accepted curve word against the oldest expectation
    always @(posedge clk)
    begin
        curve_word_t want;
        if (rst_n && curve_valid && !curve_stall)
        begin
            if (curve_due.size() == 0)
                flag_error($sformatf("unexpected word x=%0d y=%0d index_error=%0b",
                                     curve_x, curve_y, index_error));
            else
            begin
                want = curve_due.pop_front();
                if (curve_x !== want.x)
                    flag_error($sformatf("curve_x expected %0d got %0d", want.x, curve_x));
                if (curve_y !== want.y)
                    flag_error($sformatf("curve_y expected %0d got %0d", want.y, curve_y));
                if (index_error !== want.err)
                    flag_error($sformatf("index_error expected %0b got %0b",
                                         want.err, index_error));
            end
            curves_seen++;
        end
    end

    // End the run if nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (curve_valid && !curve_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("tb_hermite_curve_sampler_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        start_x      = '0;
        start_y      = '0;
        end_x        = '0;
        end_y        = '0;
        start_slope  = '0;
        end_slope    = '0;
        sample_index = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_flow(10, 64, 280);
        test_random_flow(64, 10, 280);
        test_random_flow(0, 0, 280);

        // let any stray words surface before judging
        wait_drained();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("tb_hermite_curve_sampler_top: done, clean");
        else
            $display("tb_hermite_curve_sampler_top: done, errors");
        $finish;
    end

endmodule

@@ hermite_curve_sampler_top.f @@
hdl/hcs_pkg.sv
hdl/hcs_divider.sv
hdl/hcs_basis.sv
hdl/hcs_combine.sv
hdl/hermite_curve_sampler_top.sv
verif/tb_hermite_curve_sampler_top.sv
